// ===== rtl/container_id_check_digit_assert.svh =====
// assertion macros shared by the checker
`ifndef CONTAINER_ID_CHECK_DIGIT_ASSERT_SVH
`define CONTAINER_ID_CHECK_DIGIT_ASSERT_SVH

// implication checked in the same cycle, masked while reset is high
`define CCD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication checked in the following cycle, masked while reset is high
`define CCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// implication with no reset masking
`define CCD_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/ccd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ccd_pkg;

   localparam logic [7:0] CHAR_CASE_MASK = 8'hDF;
   localparam logic [7:0] ASCII_UPPER_A  = 8'd65;
   localparam logic [7:0] ASCII_UPPER_J  = 8'd74;
   localparam logic [7:0] ASCII_UPPER_K  = 8'd75;
   localparam logic [7:0] ASCII_UPPER_U  = 8'd85;
   localparam logic [7:0] ASCII_UPPER_Z  = 8'd90;
   localparam logic [7:0] ASCII_ZERO     = 8'd48;
   localparam logic [7:0] ASCII_NINE     = 8'd57;

   // letter values skip 11, 22 and 33
   localparam logic [5:0] VALUE_A        = 6'd10;
   localparam logic [7:0] OFFSET_B_TO_K  = 8'd54;
   localparam logic [7:0] OFFSET_L_TO_U  = 8'd53;
   localparam logic [7:0] OFFSET_V_TO_Z  = 8'd52;

   localparam logic [3:0] POS_OWNER      = 4'd3;
   localparam logic [3:0] POS_CHECK      = 4'd10;
   localparam logic [3:0] POS_FULL       = 4'd11;
   localparam logic [3:0] POS_SAT        = 4'd12;

   localparam int unsigned SUM_WIDTH     = 14;
   localparam int unsigned TERM_WIDTH    = 15;
   localparam logic [3:0]  CHECK_MODULUS = 4'd11;
   localparam logic [3:0]  REM_WRAP      = 4'd10;
   // floor(s * 5958 / 2^16) equals floor(s / 11) for every 14-bit s
   localparam logic [12:0] RECIP_11      = 13'd5958;
   localparam int unsigned RECIP_SHIFT   = 16;

   typedef struct packed {
      logic       is_letter;
      logic       is_owner_code;
      logic       is_digit;
      logic [5:0] value;
   } char_class_type;

endpackage

`default_nettype wire

// ===== rtl/container_id_check_digit.sv =====
// path: a final character's result passes the input, finish and result
// registers and is held on the output until it is taken
// throughput: one character per cycle unless a final character waits for room;
// characters that are not final keep flowing while a result waits on the output
// reset: synchronous, active high; clears the position, sum, form flag, given digit and all valid bits
`timescale 1ns / 1ps
`default_nettype none

module container_id_check_digit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] char_code
   input  wire logic       req_tlast,   // last_char
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [0] id_ok, [4:1] computed_digit, [7:5] zero
);

   localparam int unsigned SW = ccd_pkg::SUM_WIDTH;
   localparam int unsigned TW = ccd_pkg::TERM_WIDTH;
   localparam int unsigned PW = SW + 13;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_last_ff;

   // per-identifier state
   logic [3:0]    pos_ff, pos_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic          err_ff, err_in;
   logic [7:0]    given_ff, given_in;

   // finish register
   logic          fin_valid_ff, fin_valid_in;
   logic [SW-1:0] fin_sum_ff;
   logic          fin_err_ff;
   logic          fin_full_ff;
   logic [7:0]    fin_given_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   logic       out_ok_ff;
   logic [3:0] out_digit_ff;

   logic out_ready, fin_ready, acc_go, in_ready;

   ccd_pkg::char_class_type cls;
   logic [TW-1:0] term;
   logic          add_term;

   logic [PW-1:0] prod;
   logic [10:0]   quot;
   logic [SW-1:0] quot_x11;
   logic [SW-1:0] rem_wide;
   logic [3:0]    rem;
   logic [3:0]    digit;
   logic [7:0]    digit_char;
   logic          ok;

   ccd_char_decode u_decode (
      .char_code  (in_char_ff),
      .char_class (cls)
   );

   // handshake chain: only a final character needs room downstream
   always_comb begin
      out_ready  = !out_valid_ff || rsp_tready;
      fin_ready  = !fin_valid_ff || out_ready;
      acc_go     = in_valid_ff && (!in_last_ff || fin_ready);
      in_ready   = !in_valid_ff || acc_go;
      req_tready = in_ready;
   end

   // position-dependent form check and weighted accumulation
   always_comb begin
      term     = TW'(cls.value) << pos_ff;
      add_term = 1'b0;
      err_in   = err_ff;
      given_in = given_ff;

      if (pos_ff < ccd_pkg::POS_OWNER) begin
         if (cls.is_letter) begin
            add_term = 1'b1;
         end else begin
            err_in = 1'b1;
         end
      end else if (pos_ff == ccd_pkg::POS_OWNER) begin
         // wrong category letter still adds its value
         if (cls.is_letter) begin
            add_term = 1'b1;
            if (!cls.is_owner_code) begin
               err_in = 1'b1;
            end
         end else begin
            err_in = 1'b1;
         end
      end else if (pos_ff < ccd_pkg::POS_CHECK) begin
         if (cls.is_digit) begin
            add_term = 1'b1;
         end else begin
            err_in = 1'b1;
         end
      end else if (pos_ff == ccd_pkg::POS_CHECK) begin
         given_in = in_char_ff;
      end

      sum_in = add_term ? (sum_ff + term[SW-1:0]) : sum_ff;
      pos_in = (pos_ff < ccd_pkg::POS_SAT) ? (pos_ff + 4'd1) : ccd_pkg::POS_SAT;
   end

   // modulo 11 by reciprocal multiply and one correction-free subtract
   always_comb begin
      prod       = PW'(fin_sum_ff) * PW'(ccd_pkg::RECIP_11);
      quot       = prod[ccd_pkg::RECIP_SHIFT +: 11];
      quot_x11   = (SW'(quot) << 3) + (SW'(quot) << 1) + SW'(quot);
      rem_wide   = fin_sum_ff - quot_x11;
      rem        = rem_wide[3:0];
      digit      = (rem == ccd_pkg::REM_WRAP) ? 4'd0 : rem;
      digit_char = ccd_pkg::ASCII_ZERO + {4'd0, digit};
      ok         = fin_full_ff && !fin_err_ff && (fin_given_ff == digit_char);
   end

   always_comb begin
      in_valid_in = in_ready ? (req_tvalid && req_tready) : in_valid_ff;
      if (in_ready) begin
         in_valid_in = req_tvalid;
      end

      fin_valid_in = fin_valid_ff;
      if (fin_valid_ff && out_ready) begin
         fin_valid_in = 1'b0;
      end
      if (acc_go && in_last_ff) begin
         fin_valid_in = 1'b1;
      end

      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (fin_valid_ff && out_ready) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= 4'd0;
         sum_ff       <= '0;
         err_ff       <= 1'b0;
         given_ff     <= 8'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         fin_valid_ff <= fin_valid_in;
         out_valid_ff <= out_valid_in;

         if (acc_go) begin
            if (in_last_ff) begin
               pos_ff   <= 4'd0;
               sum_ff   <= '0;
               err_ff   <= 1'b0;
               given_ff <= 8'd0;
            end else begin
               pos_ff   <= pos_in;
               sum_ff   <= sum_in;
               err_ff   <= err_in;
               given_ff <= given_in;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_ready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (acc_go && in_last_ff) begin
         fin_sum_ff   <= sum_in;
         fin_err_ff   <= err_in;
         fin_full_ff  <= (pos_in == ccd_pkg::POS_FULL);
         fin_given_ff <= given_in;
      end
      if (fin_valid_ff && out_ready) begin
         out_ok_ff    <= ok;
         out_digit_ff <= digit;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, out_digit_ff, out_ok_ff};

endmodule

`default_nettype wire

// ===== rtl/ccd_char_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ccd_char_decode (
   input  wire logic [7:0]          char_code,
   output ccd_pkg::char_class_type  char_class
);

   logic [7:0] upper;
   logic [7:0] letter_val;
   logic [7:0] digit_val;

   always_comb begin
      upper = char_code & ccd_pkg::CHAR_CASE_MASK;
      digit_val = char_code - ccd_pkg::ASCII_ZERO;

      if (upper <= ccd_pkg::ASCII_UPPER_K) begin
         letter_val = upper - ccd_pkg::OFFSET_B_TO_K;
      end else if (upper <= ccd_pkg::ASCII_UPPER_U) begin
         letter_val = upper - ccd_pkg::OFFSET_L_TO_U;
      end else begin
         letter_val = upper - ccd_pkg::OFFSET_V_TO_Z;
      end

      char_class.is_letter = upper inside {[ccd_pkg::ASCII_UPPER_A:ccd_pkg::ASCII_UPPER_Z]};
      char_class.is_digit  = char_code inside {[ccd_pkg::ASCII_ZERO:ccd_pkg::ASCII_NINE]};
      char_class.is_owner_code = upper inside {ccd_pkg::ASCII_UPPER_J,
                                               ccd_pkg::ASCII_UPPER_U,
                                               ccd_pkg::ASCII_UPPER_Z};

      if (char_class.is_digit) begin
         char_class.value = digit_val[5:0];
      end else if (upper == ccd_pkg::ASCII_UPPER_A) begin
         char_class.value = ccd_pkg::VALUE_A;
      end else begin
         char_class.value = letter_val[5:0];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ccd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "container_id_check_digit_assert.svh"

module ccd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata
);

   // a stalled result transaction holds
   `CCD_ASSERT_NEXT(a_rsp_valid_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `CCD_ASSERT_NEXT(a_rsp_data_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

   // computed digit stays in 0..9 and padding stays zero
   `CCD_ASSERT_SAME(a_digit_range, clock, reset, rsp_tvalid,
                    (rsp_tdata[4:1] <= 4'd9) && (rsp_tdata[7:5] == 3'd0))

   // no result transaction right after reset
   `CCD_ASSERT_ALWAYS(a_reset_empty, clock, reset, ##1 !rsp_tvalid)

endmodule

bind container_id_check_digit ccd_checker u_ccd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
